// ===== sv/sprt_pkg.sv =====
// Package: shared types, constants and helpers of the routing table block.
`timescale 1ns / 1ps
package sprt_pkg;

   localparam int MAX_NODES    = 16;
   localparam int NODE_W       = 4;
   localparam int COUNT_W      = 5;
   localparam int DIST_W       = 10;
   localparam logic [DIST_W-1:0] NO_LINK_COST = 10'd999;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Command handed from the front end to the back end
   typedef struct packed {
      logic                is_query;
      logic                bad;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [DIST_W-1:0]   link_cost;
      logic [NODE_W-1:0]   source_node;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_RELAX,
      ST_ROW,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Clamp the node count register into the supported range
   function automatic logic [COUNT_W-1:0] active_nodes(input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W-1:0] n;
      n = cnt;
      if (n < COUNT_W'(2)) n = COUNT_W'(2);
      if (n > COUNT_W'(MAX_NODES)) n = COUNT_W'(MAX_NODES);
      return n;
   endfunction

   // Zero or a cost at or above the cap means no link
   function automatic logic [DIST_W-1:0] link_weight(input logic [DIST_W-1:0] c);
      if (c == '0 || c >= NO_LINK_COST) return NO_LINK_COST;
      return c;
   endfunction

endpackage

// ===== sv/sprt_front.sv =====
// Front end: classifies incoming items and queues them for the back end.
`timescale 1ns / 1ps
module sprt_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [3:0]                   req_from_node,
   input  logic [3:0]                   req_to_node,
   input  logic [9:0]                   req_link_cost,
   input  logic [3:0]                   req_source_node,
   input  logic [sprt_pkg::COUNT_W-1:0] node_num,
   output logic                         cmd_valid,
   output sprt_pkg::cmd_type            cmd,
   input  logic                         cmd_pop
);
   import sprt_pkg::*;

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   cmd_type     new_cmd;

   // Classify the incoming item
   always_comb begin
      new_cmd.is_query    = (req_opcode == OP_QUERY);
      new_cmd.bad         = ({1'b0, req_source_node} >= node_num);
      new_cmd.from_node   = req_from_node;
      new_cmd.to_node     = req_to_node;
      new_cmd.link_cost   = req_link_cost;
      new_cmd.source_node = req_source_node;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the transfer into the queue
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== sv/sprt_back.sv =====
// Back end: cost memory, Dijkstra sequencer and routing row output.
`timescale 1ns / 1ps
module sprt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sprt_pkg::COUNT_W-1:0] node_num,
   input  logic                         cmd_valid,
   input  sprt_pkg::cmd_type            cmd,
   output logic                         cmd_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [3:0]                   rsp_dest_node,
   output logic [3:0]                   rsp_next_hop,
   output logic [3:0]                   rsp_pred_hop,
   output logic [9:0]                   rsp_path_distance,
   output logic                         rsp_bad_source,
   output logic                         rsp_last_row
);
   import sprt_pkg::*;

   logic [DIST_W-1:0]  cost_mem [MAX_NODES*MAX_NODES];
   logic [DIST_W-1:0]  rd_data_ff;
   logic [NODE_W-1:0]  rd_idx_ff;
   logic               rd_vld_ff;

   logic [DIST_W-1:0]  dist_ff [MAX_NODES];
   logic [NODE_W-1:0]  prev_ff [MAX_NODES];
   logic [MAX_NODES-1:0] vis_ff;

   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  src_ff;
   logic [NODE_W-1:0]  row_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic [COUNT_W-1:0] step_ff;
   logic [DIST_W-1:0]  best_ff;
   logic [NODE_W-1:0]  pick_ff;
   logic               found_ff;
   logic [NODE_W-1:0]  out_ff;
   logic [NODE_W-1:0]  hop_ff;
   logic [NODE_W-1:0]  nxt_ff;
   logic               bad_ff;

   logic               rsp_valid_ff;
   logic [3:0]         dest_ff, nhop_ff, phop_ff;
   logic [9:0]         pdist_ff;
   logic               bad_out_ff, last_ff;

   logic               issue;
   logic               rd_last;
   logic               scan_hit;
   logic               scan_last;
   logic               found_nx;
   logic [DIST_W-1:0]  best_nx;
   logic [NODE_W-1:0]  pick_nx;
   logic               slot_free;
   logic               row_last;
   logic [NODE_W-1:0]  last_idx;
   logic [DIST_W:0]    cand;
   logic [DIST_W-1:0]  weight;

   assign last_idx  = NODE_W'(node_num - COUNT_W'(1));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rd_last   = rd_vld_ff && (rd_idx_ff == last_idx);
   assign weight    = link_weight(rd_data_ff);
   assign cand      = {1'b0, best_ff} + {1'b0, weight};

   // Scan step: keep the nearest unvisited node, lowest index on ties
   assign scan_hit  = !vis_ff[idx_ff[NODE_W-1:0]] && (dist_ff[idx_ff[NODE_W-1:0]] < best_ff);
   assign scan_last = (idx_ff[NODE_W-1:0] == last_idx);
   assign found_nx  = found_ff || scan_hit;
   assign best_nx   = scan_hit ? dist_ff[idx_ff[NODE_W-1:0]] : best_ff;
   assign pick_nx   = scan_hit ? idx_ff[NODE_W-1:0] : pick_ff;

   assign row_last  = (out_ff == last_idx) ||
                      ((out_ff == last_idx - NODE_W'(1)) && (src_ff == last_idx));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.is_query) begin
               state_in = cmd.bad ? ST_EMIT : ST_INIT;
            end
         end
         ST_INIT: begin
            if (rd_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = found_nx ? ST_RELAX : ST_ROW;
         end
         ST_RELAX: begin
            if (rd_last) state_in = (step_ff == node_num - COUNT_W'(1)) ? ST_ROW : ST_SCAN;
         end
         ST_ROW: begin
            if (out_ff != src_ff) begin
               state_in = (prev_ff[out_ff] == src_ff) ? ST_EMIT : ST_WALK;
            end
         end
         ST_WALK: begin
            if (prev_ff[hop_ff] == src_ff) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) state_in = (bad_ff || row_last) ? ST_IDLE : ST_ROW;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes
   always_comb begin
      cmd_pop = 1'b0;
      issue   = 1'b0;
      case (state_ff)
         ST_IDLE:  cmd_pop = cmd_valid;
         ST_INIT:  issue   = (idx_ff < node_num);
         ST_RELAX: issue   = (idx_ff < node_num);
         default: begin
            cmd_pop = 1'b0;
            issue   = 1'b0;
         end
      endcase
   end

   // Cost memory: load writes, registered row reads
   always_ff @(posedge clock) begin
      if (cmd_pop && !cmd.is_query) begin
         cost_mem[{cmd.from_node, cmd.to_node}] <= cmd.link_cost;
      end
      rd_data_ff <= cost_mem[{row_ff, idx_ff[NODE_W-1:0]}];
      rd_idx_ff  <= idx_ff[NODE_W-1:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (state_ff == ST_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sequencer datapath
   always_ff @(posedge clock) begin
      if (issue) idx_ff <= idx_ff + COUNT_W'(1);
      case (state_ff)
         ST_IDLE: begin
            src_ff <= cmd.source_node;
            row_ff <= cmd.source_node;
            bad_ff <= cmd.bad;
            idx_ff <= '0;
         end
         ST_INIT: begin
            if (rd_vld_ff) begin
               dist_ff[rd_idx_ff] <= (rd_idx_ff == src_ff) ? '0 : weight;
               prev_ff[rd_idx_ff] <= src_ff;
               vis_ff[rd_idx_ff]  <= (rd_idx_ff == src_ff);
            end
            if (rd_last) begin
               step_ff  <= COUNT_W'(1);
               idx_ff   <= '0;
               best_ff  <= NO_LINK_COST;
               found_ff <= 1'b0;
               pick_ff  <= '0;
            end
         end
         ST_SCAN: begin
            best_ff  <= best_nx;
            pick_ff  <= pick_nx;
            found_ff <= found_nx;
            if (scan_last) begin
               idx_ff <= '0;
               out_ff <= '0;
               row_ff <= pick_nx;
               if (found_nx) vis_ff[pick_nx] <= 1'b1;
            end else begin
               idx_ff <= idx_ff + COUNT_W'(1);
            end
         end
         ST_RELAX: begin
            if (rd_vld_ff && !vis_ff[rd_idx_ff] && (cand < {1'b0, dist_ff[rd_idx_ff]})) begin
               dist_ff[rd_idx_ff] <= cand[DIST_W-1:0];
               prev_ff[rd_idx_ff] <= pick_ff;
            end
            if (rd_last) begin
               step_ff  <= step_ff + COUNT_W'(1);
               idx_ff   <= '0;
               best_ff  <= NO_LINK_COST;
               found_ff <= 1'b0;
               pick_ff  <= '0;
            end
         end
         ST_ROW: begin
            if (out_ff == src_ff) begin
               out_ff <= out_ff + NODE_W'(1);
            end else begin
               hop_ff <= prev_ff[out_ff];
               nxt_ff <= out_ff;
            end
         end
         ST_WALK: begin
            if (prev_ff[hop_ff] == src_ff) begin
               nxt_ff <= hop_ff;
            end else begin
               hop_ff <= prev_ff[hop_ff];
            end
         end
         ST_EMIT: begin
            if (slot_free) out_ff <= out_ff + NODE_W'(1);
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && slot_free) begin
         if (bad_ff) begin
            dest_ff    <= '0;
            nhop_ff    <= '0;
            phop_ff    <= '0;
            pdist_ff   <= NO_LINK_COST;
            bad_out_ff <= 1'b1;
            last_ff    <= 1'b1;
         end else begin
            dest_ff    <= out_ff;
            nhop_ff    <= nxt_ff;
            phop_ff    <= prev_ff[out_ff];
            pdist_ff   <= dist_ff[out_ff];
            bad_out_ff <= 1'b0;
            last_ff    <= row_last;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dest_node     = dest_ff;
   assign rsp_next_hop      = nhop_ff;
   assign rsp_pred_hop      = phop_ff;
   assign rsp_path_distance = pdist_ff;
   assign rsp_bad_source    = bad_out_ff;
   assign rsp_last_row      = last_ff;

endmodule

// ===== sv/shortest_path_routing_table_top.sv =====
// Top level: shortest path routing table with node count register.
// Use: push load items (opcode 0) on req_* to write link costs into the
// 16x16 cost memory, then a query item (opcode 1) naming a source node.
// Each query returns one routing row per other node on rsp_*, ascending by
// destination, with last_row on the final one; a source at or beyond the
// node count returns a single row with bad_source set.
// csr_* writes the node count (clamped to 2..16); csr_ready is always high.
// The user must make writes only while the block is idle; the block itself does not enforce this.
// A load is written into the cost memory when the idle back end takes it. A query
// with N nodes first fills the distance table, then runs up to N-1 rounds
// of a scan and a relax pass through the single memory read port, then
// walks the predecessors for each row and outputs it.
// A two-entry queue sits between front and back end, so up to two items
// are taken while a query runs; req_stall rises when it is full.
// When rsp_stall is high the current row holds and the sequencer waits.
// Reset (synchronous) empties the queue, drops any pending row and sets
// the node count to 16; the cost memory keeps no reset value.
`timescale 1ns / 1ps
module shortest_path_routing_table_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [3:0] req_from_node,
   input  logic [3:0] req_to_node,
   input  logic [9:0] req_link_cost,
   input  logic [3:0] req_source_node,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_dest_node,
   output logic [3:0] rsp_next_hop,
   output logic [3:0] rsp_pred_hop,
   output logic [9:0] rsp_path_distance,
   output logic       rsp_bad_source,
   output logic       rsp_last_row,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);
   import sprt_pkg::*;

   logic [COUNT_W-1:0] node_count_ff;
   logic [COUNT_W-1:0] node_num;
   logic               cmd_valid;
   logic               cmd_pop;
   cmd_type            cmd;

   // Hold the node count register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(MAX_NODES);
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   assign node_num = active_nodes(node_count_ff);

   sprt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_from_node   (req_from_node),
      .req_to_node     (req_to_node),
      .req_link_cost   (req_link_cost),
      .req_source_node (req_source_node),
      .node_num        (node_num),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   sprt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .node_num          (node_num),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_node     (rsp_dest_node),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_pred_hop      (rsp_pred_hop),
      .rsp_path_distance (rsp_path_distance),
      .rsp_bad_source    (rsp_bad_source),
      .rsp_last_row      (rsp_last_row)
   );

endmodule

// ===== dv/testbench.sv =====
// Testbench: checks the shortest path routing table block against a built-in predictor.
`timescale 1ns / 1ps
module testbench;
   import sprt_pkg::*;

   typedef struct {
      logic       opcode;
      logic [3:0] from_node;
      logic [3:0] to_node;
      logic [9:0] link_cost;
      logic [3:0] source_node;
   } route_req_t;

   typedef struct {
      logic [3:0] dest_node;
      logic [3:0] next_hop;
      logic [3:0] pred_hop;
      logic [9:0] path_distance;
      logic       bad_source;
      logic       last_row;
   } route_row_t;

   logic       clock, reset;
   logic       req_valid, req_stall, req_opcode;
   logic [3:0] req_from_node, req_to_node, req_source_node;
   logic [9:0] req_link_cost;
   logic       rsp_valid, rsp_stall;
   logic [3:0] rsp_dest_node, rsp_next_hop, rsp_pred_hop;
   logic [9:0] rsp_path_distance;
   logic       rsp_bad_source, rsp_last_row;
   logic       csr_valid, csr_ready;
   logic [4:0] csr_data;

   route_req_t pending_q[$];
   route_row_t route_rows_q[$];
   logic [9:0] link_table[256];
   logic [4:0] node_count_reg;
   bit         gen_written[256];
   int         send_idle_pct, recv_idle_pct;
   bit         req_taken;
   int         mismatches;

   shortest_path_routing_table_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // Predict the routing rows for one query
   function automatic void predict_routes(input logic [3:0] src);
      int n, dist_tab[16], prev[16], best, pick, cand, j, hop, nxt;
      bit seen[16], found;
      route_row_t row;
      n = node_count_reg;
      if (n < 2) n = 2;
      if (n > MAX_NODES) n = MAX_NODES;
      if (src >= n) begin
         row = '{4'd0, 4'd0, 4'd0, NO_LINK_COST, 1'b1, 1'b1};
         route_rows_q.push_back(row);
         return;
      end
      for (int i = 0; i < n; i++) begin
         dist_tab[i] = link_weight(link_table[src*16+i]);
         prev[i] = src;
         seen[i] = 0;
      end
      dist_tab[src] = 0;
      seen[src] = 1;
      for (int s = 1; s < n; s++) begin
         best = NO_LINK_COST;
         pick = 0;
         found = 0;
         for (int i = 0; i < n; i++)
            if (!seen[i] && dist_tab[i] < best) begin
               best = dist_tab[i];
               pick = i;
               found = 1;
            end
         if (!found) break;
         seen[pick] = 1;
         for (int i = 0; i < n; i++)
            if (!seen[i]) begin
               cand = best + link_weight(link_table[pick*16+i]);
               if (cand < dist_tab[i]) begin
                  dist_tab[i] = cand;
                  prev[i] = pick;
               end
            end
      end
      for (int i = 0; i < n; i++) begin
         if (i == src) continue;
         if (prev[i] == src) nxt = i;
         else begin
            j = i;
            hop = i;
            for (int g = 0; g < n && j != src; g++) begin
               hop = j;
               j = prev[j];
               if (j >= n) j = src;
            end
            nxt = (hop == i) ? src : hop;
         end
         row.dest_node = 4'(i);
         row.next_hop = 4'(nxt);
         row.pred_hop = 4'(prev[i]);
         row.path_distance = 10'(dist_tab[i]);
         row.bad_source = 1'b0;
         row.last_row = (i == n - 1) || (i == n - 2 && src == n - 1);
         route_rows_q.push_back(row);
      end
   endfunction

   // Drive request transfers and receiver stall
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (!req_valid || req_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               route_req_t it;
               it = pending_q.pop_front();
               req_valid <= 1'b1;
               req_opcode <= it.opcode;
               req_from_node <= it.from_node;
               req_to_node <= it.to_node;
               req_link_cost <= it.link_cost;
               req_source_node <= it.source_node;
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   // Monitor transfers on both channels and check rows
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) node_count_reg = csr_data;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            if (req_opcode == OP_LOAD) link_table[{req_from_node, req_to_node}] = req_link_cost;
            else predict_routes(req_source_node);
         end
         if (rsp_valid && !rsp_stall) begin
            if (route_rows_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected row dest=%0d", rsp_dest_node);
            end else begin
               route_row_t e;
               e = route_rows_q.pop_front();
               if (e.dest_node !== rsp_dest_node || e.next_hop !== rsp_next_hop ||
                   e.pred_hop !== rsp_pred_hop || e.path_distance !== rsp_path_distance ||
                   e.bad_source !== rsp_bad_source || e.last_row !== rsp_last_row) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("row mismatch exp %0d/%0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0d/%0b/%0b",
                        e.dest_node, e.next_hop, e.pred_hop, e.path_distance, e.bad_source,
                        e.last_row, rsp_dest_node, rsp_next_hop, rsp_pred_hop,
                        rsp_path_distance, rsp_bad_source, rsp_last_row);
               end
            end
         end
      end
   end

   task automatic push_load(input int f, input int t, input int c);
      route_req_t it;
      it = '{OP_LOAD, f[3:0], t[3:0], c[9:0], 4'($urandom)};
      gen_written[f*16+t] = 1;
      pending_q.push_back(it);
   endtask

   task automatic push_query(input int s);
      route_req_t it;
      it = '{OP_QUERY, 4'($urandom), 4'($urandom), 10'($urandom), s[3:0]};
      pending_q.push_back(it);
   endtask

   function automatic int rand_cost();
      int r;
      r = $urandom_range(7);
      if (r < 2) return 0;
      if (r == 2) return $urandom_range(999, 1023);
      if (r == 3) return $urandom_range(1, 998);
      return $urandom_range(1, 60);
   endfunction

   // Wait for every queued item and row, then let the back end settle
   task automatic wait_drained();
      while (pending_q.size() > 0 || req_valid || route_rows_q.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [4:0] v);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Fill any unwritten cost entry the queries can read
   task automatic fill_costs(input int n);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (!gen_written[i*16+j]) push_load(i, j, rand_cost());
   endtask

   task automatic random_phase(input logic [4:0] cnt, input int items);
      int n;
      n = (cnt < 2) ? 2 : (cnt > 16) ? 16 : cnt;
      write_node_count(cnt);
      fill_costs(n);
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(99) < 55) begin
            if ($urandom_range(9) == 0) push_query($urandom_range(15));
            else push_query($urandom_range(n - 1));
         end else begin
            push_load($urandom_range(15), $urandom_range(15), rand_cost());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_LOAD;
      req_from_node = '0;
      req_to_node = '0;
      req_link_cost = '0;
      req_source_node = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      req_taken = 1'b0;
      node_count_reg = 5'd16;
      mismatches = 0;
      send_idle_pct = 30;
      recv_idle_pct = 72;
      foreach (link_table[i]) link_table[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: chain with ties, unreachable node, big costs, bad source
      write_node_count(5'd4);
      fill_costs(4);
      push_load(0, 1, 1);
      push_load(1, 2, 1);
      push_load(0, 2, 2);
      push_load(2, 3, 1023);
      push_load(0, 3, 999);
      push_load(3, 0, 998);
      push_load(15, 15, 1023);
      push_query(0);
      push_query(3);
      push_query(15);
      push_query(4);
      push_load(2, 3, 997);
      push_query(0);
      push_load(1, 3, 1);
      push_query(0);
      push_query(2);
      random_phase(5'd5, 30);

      send_idle_pct = 72;
      recv_idle_pct = 30;
      random_phase(5'd2, 20);
      random_phase(5'd9, 40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(5'd0, 15);

      // Node count above the maximum: a source with no links stops at once
      write_node_count(5'd31);
      for (int j = 0; j < 16; j++) push_load(15, j, 0);
      push_query(15);

      wait_drained();
      if (mismatches == 0 && route_rows_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
